>>> design/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_POP_BACK   = 3'd1,
    KIND_PUSH_FRONT = 3'd2,
    KIND_PEEK_FRONT = 3'd3,
    KIND_PEEK_BACK  = 3'd4,
    KIND_CLEAR      = 3'd5
  } kind_e;

endpackage

>>> design/circular_deque.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// request   in         start_i & !busy_o       kind_i, item_value_i
// result    out        done_o (one cycle)      ok_o, read_value_o, now_empty_o, now_full_o
//
// One request per cycle; its result strobes on done_o in the cycle after acceptance.
// The slot memory has at most one write or one read per request, read data registered once.
// A write lands at the accepting edge, so the next request already sees it.
// busy_o is high for the first cycle after reset only.
// The receiver cannot stall; results are never held back.

module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [DATA_W-1:0] item_value_i,
  output logic              done_o,
  output logic              ok_o,
  output logic [DATA_W-1:0] read_value_o,
  output logic              now_empty_o,
  output logic              now_full_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [WORD_BITS-1:0] mem_q [SLOTS];
  logic [WORD_BITS-1:0] rdata_q;

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic             busy_q;
  logic             done_q;
  logic             ok_q, ok_d;
  logic             rd_q, rd_d;
  logic             empty_q, full_q;

  logic             accept;
  logic             empty_now, full_now;
  logic [IDX_W-1:0] tail_next, tail_prev, head_prev, head_next_d_chk;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] waddr, raddr;
  logic [63:0]      item_ext;
  logic [63:0]      rdata_ext;
  logic [WORD_BITS-1:0] wdata;

  assign accept    = start_i & ~busy_q;
  assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
  assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - IDX_W'(1);
  assign head_prev = (head_q == '0) ? LAST_IDX : head_q - IDX_W'(1);
  assign empty_now = (head_q == tail_q);
  assign full_now  = (tail_next == head_q);

  assign item_ext = 64'(item_value_i);
  assign wdata    = item_ext[WORD_BITS-1:0];

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    ok_d   = 1'b0;
    rd_d   = 1'b0;
    wr_en  = 1'b0;
    rd_en  = 1'b0;
    waddr  = tail_q;
    raddr  = head_q;
    case (kind_e'(kind_i))
      KIND_PUSH_BACK: begin
        if (!full_now) begin
          wr_en  = 1'b1;
          waddr  = tail_q;
          tail_d = tail_next;
          ok_d   = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (!empty_now) begin
          rd_en  = 1'b1;
          raddr  = tail_prev;
          tail_d = tail_prev;
          ok_d   = 1'b1;
          rd_d   = 1'b1;
        end
      end
      KIND_PUSH_FRONT: begin
        if (!full_now) begin
          wr_en  = 1'b1;
          waddr  = head_prev;
          head_d = head_prev;
          ok_d   = 1'b1;
        end
      end
      KIND_PEEK_FRONT: begin
        if (!empty_now) begin
          rd_en = 1'b1;
          raddr = head_q;
          ok_d  = 1'b1;
          rd_d  = 1'b1;
        end
      end
      KIND_PEEK_BACK: begin
        if (!empty_now) begin
          rd_en = 1'b1;
          raddr = tail_prev;
          ok_d  = 1'b1;
          rd_d  = 1'b1;
        end
      end
      KIND_CLEAR: begin
        head_d = '0;
        tail_d = '0;
        ok_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign head_next_d_chk = (tail_d == LAST_IDX) ? '0 : tail_d + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (accept && rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      head_q  <= '0;
      tail_q  <= '0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
      rd_q    <= 1'b0;
      empty_q <= 1'b1;
      full_q  <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      done_q <= accept;
      if (accept) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        ok_q    <= ok_d;
        rd_q    <= rd_d;
        empty_q <= (head_d == tail_d);
        full_q  <= (head_next_d_chk == head_d);
      end
    end
  end

  assign rdata_ext    = 64'(rdata_q);
  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign read_value_o = rd_q ? rdata_ext[DATA_W-1:0] : '0;
  assign now_empty_o  = empty_q;
  assign now_full_o   = full_q;

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without transaction");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(now_empty_o && now_full_o))
    else $error("queue reported empty and full");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (read_value_o == '0))
    else $error("refused transaction returned data");
`endif

endmodule

>>> sim/deque_checker.sv
`timescale 1ns / 1ps

module deque_checker
  import cdq_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [DATA_W-1:0] item_value_i,
  input  logic              done_i,
  input  logic              ok_i,
  input  logic [DATA_W-1:0] read_value_i,
  input  logic              now_empty_i,
  input  logic              now_full_i,
  output int                pending_o,
  output int                fail_count_o
);

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic              now_empty;
    logic              now_full;
  } deque_reply_t;

  logic [DATA_W-1:0] ring_words [SLOTS];
  int unsigned       front_idx;
  int unsigned       back_idx;
  deque_reply_t      expected_replies [$];

  function automatic int unsigned ring_fwd(int unsigned idx);
    return (idx + 1) % SLOTS;
  endfunction

  function automatic int unsigned ring_back(int unsigned idx);
    return (idx + SLOTS - 1) % SLOTS;
  endfunction

  task automatic predict_reply(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] word,
                               output deque_reply_t reply);
    logic is_empty;
    logic is_full;
    reply    = '0;
    is_empty = (front_idx == back_idx);
    is_full  = (ring_fwd(back_idx) == front_idx);
    case (kind)
      KIND_PUSH_BACK: begin
        if (!is_full) begin
          ring_words[back_idx] = word;
          back_idx             = ring_fwd(back_idx);
          reply.ok             = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (!is_empty) begin
          back_idx         = ring_back(back_idx);
          reply.read_value = ring_words[back_idx];
          reply.ok         = 1'b1;
        end
      end
      KIND_PUSH_FRONT: begin
        if (!is_full) begin
          front_idx             = ring_back(front_idx);
          ring_words[front_idx] = word;
          reply.ok              = 1'b1;
        end
      end
      KIND_PEEK_FRONT: begin
        if (!is_empty) begin
          reply.read_value = ring_words[front_idx];
          reply.ok         = 1'b1;
        end
      end
      KIND_PEEK_BACK: begin
        if (!is_empty) begin
          reply.read_value = ring_words[ring_back(back_idx)];
          reply.ok         = 1'b1;
        end
      end
      KIND_CLEAR: begin
        front_idx = 0;
        back_idx  = 0;
        reply.ok  = 1'b1;
      end
      default: begin
      end
    endcase
    reply.now_empty = (front_idx == back_idx);
    reply.now_full  = (ring_fwd(back_idx) == front_idx);
  endtask

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    deque_reply_t want;
    deque_reply_t fresh;
    if (!rst_ni) begin
      front_idx    = 0;
      back_idx     = 0;
      expected_replies.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (expected_replies.size() == 0) begin
          $error("result transaction with no request waiting");
          fail_count_o++;
        end else begin
          want = expected_replies.pop_front();
          check_field("ok", DATA_W'(want.ok), DATA_W'(ok_i));
          check_field("read_value", want.read_value, read_value_i);
          check_field("now_empty", DATA_W'(want.now_empty), DATA_W'(now_empty_i));
          check_field("now_full", DATA_W'(want.now_full), DATA_W'(now_full_i));
        end
      end
      if (start_i && !busy_i) begin
        predict_reply(kind_i, item_value_i, fresh);
        expected_replies.insert(expected_replies.size(), fresh);
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

>>> sim/circular_deque_test.sv
`timescale 1ns / 1ps

module circular_deque_test;
  import cdq_pkg::*;

  localparam int unsigned     RING_SLOTS    = 16;
  localparam int              RANDOM_ITEMS  = 550;
  localparam int              CYCLE_LIMIT   = 40000;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start_i      = 1'b0;
  logic [KIND_W-1:0] kind_i       = KIND_PUSH_BACK;
  logic [DATA_W-1:0] item_value_i = '0;
  logic              busy_o;
  logic              done_o;
  logic              ok_o;
  logic [DATA_W-1:0] read_value_o;
  logic              now_empty_o;
  logic              now_full_o;
  int                pending_replies;
  int                mismatches;
  int                cycle_count  = 0;

  always #6 clk_i = ~clk_i;

  circular_deque #(
    .SLOTS    (RING_SLOTS),
    .WORD_BITS(DATA_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .item_value_i(item_value_i),
    .done_o      (done_o),
    .ok_o        (ok_o),
    .read_value_o(read_value_o),
    .now_empty_o (now_empty_o),
    .now_full_o  (now_full_o)
  );

  deque_checker #(
    .SLOTS(RING_SLOTS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .kind_i      (kind_i),
    .item_value_i(item_value_i),
    .done_i      (done_o),
    .ok_i        (ok_o),
    .read_value_i(read_value_o),
    .now_empty_i (now_empty_o),
    .now_full_i  (now_full_o),
    .pending_o   (pending_replies),
    .fail_count_o(mismatches)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] word);
    start_i      = 1'b1;
    kind_i       = kind;
    item_value_i = word;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_cycle();
    start_i = 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start_i = 1'b0;
    while (pending_replies != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(input bit fill_phase);
    int roll;
    roll = $urandom_range(0, 99);
    if (fill_phase) begin
      if (roll < 35) return KIND_PUSH_BACK;
      if (roll < 66) return KIND_PUSH_FRONT;
      if (roll < 76) return KIND_POP_BACK;
      if (roll < 84) return KIND_PEEK_FRONT;
      if (roll < 92) return KIND_PEEK_BACK;
    end else begin
      if (roll < 12) return KIND_PUSH_BACK;
      if (roll < 22) return KIND_PUSH_FRONT;
      if (roll < 62) return KIND_POP_BACK;
      if (roll < 77) return KIND_PEEK_FRONT;
      if (roll < 92) return KIND_PEEK_BACK;
    end
    if (roll < 95) return KIND_CLEAR;
    if (roll < 98) return KIND_SPARE_LO;
    return KIND_SPARE_HI;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return DATA_W'($urandom);
  endfunction

  initial begin
    bit fill_phase;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // refuse reads on an empty ring, ignore spare kinds
    send_request(KIND_POP_BACK, '1);
    send_request(KIND_PEEK_FRONT, '1);
    send_request(KIND_PEEK_BACK, '0);
    send_request(KIND_SPARE_LO, '1);
    send_request(KIND_SPARE_HI, '1);

    // fill to capacity from both ends, wrapping the front index
    send_request(KIND_PUSH_BACK, '0);
    send_request(KIND_PUSH_BACK, '1);
    send_request(KIND_PUSH_FRONT, 32'h5555_AAAA);
    for (int k = 0; k < RING_SLOTS - 4; k++) begin
      send_request((k % 2 == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_word());
    end
    send_request(KIND_PUSH_BACK, '1);
    send_request(KIND_PUSH_FRONT, '1);
    send_request(KIND_PEEK_FRONT, '0);
    send_request(KIND_PEEK_BACK, '0);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_CLEAR, '1);
    send_request(KIND_PEEK_BACK, '0);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) wait_drained();
      if (n < 200 || n >= 330) begin
        while ($urandom_range(0, 99) < 21) idle_cycle();
      end
      fill_phase = ((n / 40) % 2) == 0;
      send_request(pick_kind(fill_phase), pick_word());
    end
    wait_drained();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
